>>> rtl/rgb_median_filter_3x3_defines.svh
// ----------------------------------------------------------------------------
// rgb_median_filter_3x3_defines.svh
// Assertion macros for the checker of the median filter.
// ----------------------------------------------------------------------------
`ifndef RGB_MEDIAN_FILTER_3X3_DEFINES_SVH
`define RGB_MEDIAN_FILTER_3X3_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RMF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("median filter check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("median filter check failed");

`endif

>>> rtl/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg
// Types and constants of the 3x3 RGB median filter.
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int WINDOW     = 3;
    localparam int TAPS       = WINDOW * WINDOW;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = COL_W + 1;
    localparam int CFG_W      = 12;
    localparam int ROW_W      = 12;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;

    localparam int MIN_DIM    = 3;
    localparam int NUM_REGS   = 2;
    localparam int REG_LSB    = 2;
    localparam int IDX_W      = $clog2(NUM_REGS);
    localparam int ADDR_W     = IDX_W + REG_LSB;
    localparam int DATA_W     = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_PAD   = 1'b1;

    typedef logic [CH_W-1:0] chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_t;

endpackage

>>> rtl/rmf_if.sv
// ----------------------------------------------------------------------------
// rmf_in_if / rmf_out_if
// Valid/ready channels for incoming pixels and filtered pixels.
// ----------------------------------------------------------------------------
interface rmf_in_if import rmf_pkg::*;;
    logic  valid;
    logic  ready;
    logic  mode;
    chan_t red;
    chan_t green;
    chan_t blue;

    modport source (output valid, output mode, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input mode, input red, input green, input blue,
                    output ready);
endinterface

interface rmf_out_if import rmf_pkg::*;;
    logic  valid;
    logic  ready;
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    logic  frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_end, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input frame_end, output ready);
endinterface

>>> rtl/rgb_median_filter_3x3.sv
// ----------------------------------------------------------------------------
// rgb_median_filter_3x3
// Streaming 3x3 median filter on RGB pixels with two line stores.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the pixels channel (mode 0). Each color
// channel of an interior pixel is replaced by the median of its 3x3
// neighborhood; pixels in the first or last row or column pass unchanged.
// Results leave on the filtered channel, lagging the input by one row plus
// one pixel. Once the last pixel of a frame is in, every further request
// (pad with mode 1, or a pixel whose color is dropped) pushes out one of the
// remaining width+1 pixels; frame_end marks the last one. Pads sent earlier
// in a frame are dropped. Image size is set over the APB port; any write
// restarts the frame.
// One request is taken per clock while filtered is not stalled. A released
// result passes the registered read of the line RAMs and the read stage,
// then the output register. When filtered is stalled the whole pipeline
// holds and pixels.ready drops; it is high whenever the output register is
// empty or being emptied. Reset restores 640x480 and an empty pipeline; the
// line RAMs need no clearing.
// ----------------------------------------------------------------------------
module rgb_median_filter_3x3 import rmf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    rmf_in_if.sink            pixels,
    rmf_out_if.source         filtered,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH  = IDX_W'(0),
        REG_HEIGHT = IDX_W'(1)
    } reg_index_t;

    // configuration
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    reg_index_t       reg_sel;
    logic             cfg_wr;
    logic [WID_W-1:0] eff_w;
    logic [ROW_W-1:0] eff_h;
    logic [WID_W-1:0] eff_w_dec;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;

    // position counters
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             flushing_reg;
    logic [WID_W-1:0] fidx_reg;
    logic [WID_W-1:0] fidx_dec;

    // request decode
    logic             advance;
    logic             accept;
    logic             is_pix;
    logic             is_flush;
    logic             pix_out;
    logic             pix_med;
    logic             flush_first;
    logic             flush_last;
    logic [COL_W-1:0] rd_addr;
    pixel_t           in_pix;

    // read stage
    logic             s1_pix_reg;
    logic             s1_out_reg;
    logic             s1_med_reg;
    logic             s1_flush_reg;
    logic             s1_upper_reg;
    logic             s1_fe_reg;
    logic [COL_W-1:0] s1_col_reg;
    pixel_t           s1_data_reg;
    logic             s1_byp_reg;
    pixel_t           s1_byp_top_reg;
    pixel_t           s1_byp_mid_reg;

    logic             wr_en;
    logic             byp_next;
    logic [PIX_W-1:0] upper_rdata;
    logic [PIX_W-1:0] middle_rdata;
    pixel_t           top_rd;
    pixel_t           mid_rd;

    // window and result
    pixel_t           win_reg [WINDOW][WINDOW];
    pixel_t           nwin    [WINDOW][WINDOW];
    chan_t            red_taps   [TAPS];
    chan_t            green_taps [TAPS];
    chan_t            blue_taps  [TAPS];
    chan_t            red_med;
    chan_t            green_med;
    chan_t            blue_med;
    pixel_t           result;

    logic             out_valid_reg;
    pixel_t           out_pix_reg;
    logic             out_fe_reg;

    // ------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[ADDR_W-1:REG_LSB]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_sel)
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    // saturate the image size to the supported range
    always_comb
    begin
        if (width_reg < CFG_W'(MIN_DIM))
        begin
            eff_w = WID_W'(MIN_DIM);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = WID_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WID_W'(width_reg);
        end
        if (height_reg < CFG_W'(MIN_DIM))
        begin
            eff_h = ROW_W'(MIN_DIM);
        end
        else
        begin
            eff_h = ROW_W'(height_reg);
        end
    end

    assign eff_w_dec = eff_w - WID_W'(1);
    assign last_col  = eff_w_dec[COL_W-1:0];
    assign last_row  = eff_h - ROW_W'(1);

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    assign advance      = !out_valid_reg || filtered.ready;
    assign pixels.ready = advance;
    assign accept       = pixels.valid && advance;

    assign in_pix   = '{red: pixels.red, green: pixels.green, blue: pixels.blue};
    assign is_pix   = accept && !flushing_reg && (pixels.mode == MODE_PIXEL);
    assign is_flush = accept && flushing_reg;

    assign pix_out  = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && (col_reg != '0));
    assign pix_med  = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));

    assign flush_first = (fidx_reg == '0);
    assign flush_last  = (fidx_reg == eff_w);
    assign fidx_dec    = fidx_reg - WID_W'(1);

    always_comb
    begin
        if (!flushing_reg)
        begin
            rd_addr = col_reg;
        end
        else if (flush_first)
        begin
            rd_addr = last_col;
        end
        else
        begin
            rd_addr = fidx_dec[COL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            flushing_reg <= 1'b0;
            fidx_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            flushing_reg <= 1'b0;
            fidx_reg     <= '0;
        end
        else if (is_pix)
        begin
            if (col_reg == last_col)
            begin
                col_reg <= '0;
                if (row_reg == last_row)
                begin
                    row_reg      <= '0;
                    flushing_reg <= 1'b1;
                    fidx_reg     <= '0;
                end
                else
                begin
                    row_reg <= row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
        else if (is_flush)
        begin
            if (flush_last)
            begin
                flushing_reg <= 1'b0;
                fidx_reg     <= '0;
            end
            else
            begin
                fidx_reg <= fidx_reg + WID_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Line stores
    // ------------------------------------------------------------------
    assign wr_en = advance && s1_pix_reg;
    // a read that hits the column being written this cycle takes the new data
    assign byp_next = wr_en && (s1_col_reg == rd_addr);

    assign top_rd = s1_byp_reg ? s1_byp_top_reg : pixel_t'(upper_rdata);
    assign mid_rd = s1_byp_reg ? s1_byp_mid_reg : pixel_t'(middle_rdata);

    rmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_col_reg),
        .wr_data (mid_rd),
        .rd_en   (advance),
        .rd_addr (rd_addr),
        .rd_data (upper_rdata)
    );

    rmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_col_reg),
        .wr_data (s1_data_reg),
        .rd_en   (advance),
        .rd_addr (rd_addr),
        .rd_data (middle_rdata)
    );

    // ------------------------------------------------------------------
    // Read stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_pix_reg <= 1'b0;
            s1_out_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_pix_reg <= is_pix;
            s1_out_reg <= (is_pix && pix_out) || is_flush;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_med_reg     <= pix_med;
            s1_flush_reg   <= flushing_reg;
            s1_upper_reg   <= flush_first;
            s1_fe_reg      <= flushing_reg && flush_last;
            s1_col_reg     <= col_reg;
            s1_data_reg    <= in_pix;
            s1_byp_reg     <= byp_next;
            s1_byp_top_reg <= mid_rd;
            s1_byp_mid_reg <= s1_data_reg;
        end
    end

    // ------------------------------------------------------------------
    // Window and median
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int r = 0; r < WINDOW; r++)
        begin
            for (int c = 0; c < WINDOW - 1; c++)
            begin
                nwin[r][c] = win_reg[r][c+1];
            end
        end
        nwin[0][WINDOW-1] = top_rd;
        nwin[1][WINDOW-1] = mid_rd;
        nwin[2][WINDOW-1] = s1_data_reg;
        for (int r = 0; r < WINDOW; r++)
        begin
            for (int c = 0; c < WINDOW; c++)
            begin
                red_taps[r*WINDOW+c]   = nwin[r][c].red;
                green_taps[r*WINDOW+c] = nwin[r][c].green;
                blue_taps[r*WINDOW+c]  = nwin[r][c].blue;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            win_reg <= nwin;
        end
    end

    rmf_median9 u_med_red   (.taps(red_taps),   .median(red_med));
    rmf_median9 u_med_green (.taps(green_taps), .median(green_med));
    rmf_median9 u_med_blue  (.taps(blue_taps),  .median(blue_med));

    always_comb
    begin
        if (s1_flush_reg)
        begin
            result = s1_upper_reg ? top_rd : mid_rd;
        end
        else if (s1_med_reg)
        begin
            result = '{red: red_med, green: green_med, blue: blue_med};
        end
        else
        begin
            // edge pixel: the new window center, unfiltered
            result = win_reg[1][WINDOW-1];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_out_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pix_reg <= result;
            out_fe_reg  <= s1_fe_reg;
        end
    end

    assign filtered.valid     = out_valid_reg;
    assign filtered.out_red   = out_pix_reg.red;
    assign filtered.out_green = out_pix_reg.green;
    assign filtered.out_blue  = out_pix_reg.blue;
    assign filtered.frame_end = out_fe_reg;

endmodule

>>> rtl/rmf_ram.sv
// ----------------------------------------------------------------------------
// rmf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/rmf_median9.sv
// ----------------------------------------------------------------------------
// rmf_median9
// Median of nine 8-bit values: sort each row, then take the median of the
// largest low, the middle median and the smallest high.
// ----------------------------------------------------------------------------
module rmf_median9 import rmf_pkg::*; (
    input  chan_t taps [TAPS],
    output chan_t median
);

    function automatic chan_t min2(input chan_t a, input chan_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic chan_t max2(input chan_t a, input chan_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    chan_t row_lo  [WINDOW];
    chan_t row_mid [WINDOW];
    chan_t row_hi  [WINDOW];

    always_comb
    begin
        for (int r = 0; r < WINDOW; r++)
        begin
            row_lo[r]  = min2(min2(taps[r*WINDOW], taps[r*WINDOW+1]), taps[r*WINDOW+2]);
            row_mid[r] = med3(taps[r*WINDOW], taps[r*WINDOW+1], taps[r*WINDOW+2]);
            row_hi[r]  = max2(max2(taps[r*WINDOW], taps[r*WINDOW+1]), taps[r*WINDOW+2]);
        end
    end

    assign median = med3(max2(max2(row_lo[0], row_lo[1]), row_lo[2]),
                         med3(row_mid[0], row_mid[1], row_mid[2]),
                         min2(min2(row_hi[0], row_hi[1]), row_hi[2]));

endmodule

>>> rtl/rmf_checker.sv
// ----------------------------------------------------------------------------
// rmf_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_median_filter_3x3_defines.svh"

module rmf_checker import rmf_pkg::*; (
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input chan_t out_red,
    input chan_t out_green,
    input chan_t out_blue,
    input logic  frame_end
);

    logic [PIX_W:0] out_word;

    assign out_word = {out_red, out_green, out_blue, frame_end};

    // a stalled result stays and holds its value
    `RMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `RMF_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_word))

    // input is only held off by a stalled output
    `RMF_ASSERT_NOW(a_in_ready, !out_valid, in_ready)

    // a fresh result comes from an earlier accepted request, through the read stage and the output register
    `RMF_ASSERT_NOW(a_out_after_req, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind rgb_median_filter_3x3 rmf_checker u_rmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixels.valid),
    .in_ready  (pixels.ready),
    .out_valid (filtered.valid),
    .out_ready (filtered.ready),
    .out_red   (filtered.out_red),
    .out_green (filtered.out_green),
    .out_blue  (filtered.out_blue),
    .frame_end (filtered.frame_end)
);

>>> test/rgb_median_filter_3x3_test.sv
// ----------------------------------------------------------------------------
// rgb_median_filter_3x3_test
// Self-checking bench for the streaming 3x3 RGB median filter.
// ----------------------------------------------------------------------------
// Pixel requests go in on one valid/ready channel and filtered pixels come
// back on another. A line-store model of the filter, kept in step with every
// accepted request, queues the pixel it expects next, and every accepted
// result is checked against the oldest queued pixel. Image size is set over
// APB and read back. The run covers a hand-built 3x3 frame, size extremes
// and clamping, a long output stall, a sender pause, abandoned frames and
// many random small frames with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module rgb_median_filter_3x3_test;
    import rmf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_WIDTH      = 0;
    localparam int REG_HEIGHT     = 1;
    localparam int MAX_HEIGHT     = 4095;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_STALL     = 300;
    localparam int RANDOM_ITEMS   = 1000;

    typedef enum int {COLOR_FULL, COLOR_EXTREME, COLOR_NARROW} color_style_t;

    typedef struct {
        pixel_t color;
        logic   frame_end;
    } out_pixel_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    rmf_in_if  pixel_ch ();
    rmf_out_if result_ch ();

    rgb_median_filter_3x3 uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixels   (pixel_ch),
        .filtered (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Filter model state
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;
    pixel_t           upper_store [MAX_WIDTH];
    pixel_t           middle_store [MAX_WIDTH];
    pixel_t           nbr_window [TAPS];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      emitted;

    out_pixel_t       expected_pixels [$];

    // Stimulus controls
    bit               tx_idle_en;
    bit               rx_idle_en;
    bit               pad_noise;
    color_style_t     color_style;
    int               stall_request;

    // Bookkeeping
    int               mismatch_count;
    int               effective_items;
    int               pads_dropped;
    int               results_checked;
    int               frames_done;
    int               quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Model of the filter
    // ------------------------------------------------------------------------
    function automatic int unsigned eff_width();
        int unsigned w;
        w = cfg_width;
        if (w < MIN_DIM)
            w = MIN_DIM;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = cfg_height;
        if (h < MIN_DIM)
            h = MIN_DIM;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic void restart_frame_model();
        col_pos = 0;
        row_pos = 0;
        emitted = 0;
    endfunction

    function automatic void reset_model();
        cfg_width  = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_store[i]  = '0;
            middle_store[i] = '0;
        end
        for (int i = 0; i < TAPS; i++)
            nbr_window[i] = '0;
        restart_frame_model();
    endfunction

    function automatic chan_t window_median(input int shift);
        chan_t v [TAPS];
        chan_t key;
        int    j;
        for (int i = 0; i < TAPS; i++)
            v[i] = chan_t'(nbr_window[i] >> shift);
        for (int i = 1; i < TAPS; i++)
        begin
            key = v[i];
            j = i - 1;
            while (j >= 0 && v[j] > key)
            begin
                v[j + 1] = v[j];
                j--;
            end
            v[j + 1] = key;
        end
        return v[TAPS / 2];
    endfunction

    // Advance the model by one accepted request; returns 1 when it yields a pixel.
    function automatic bit filter_request(input logic mode, input pixel_t color,
                                          output out_pixel_t res);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned first_out;
        int unsigned idx;
        int unsigned c;
        int unsigned r;
        pixel_t      top;
        pixel_t      mid;
        w = eff_width();
        h = eff_height();
        res.color     = '0;
        res.frame_end = 1'b0;
        if (row_pos >= h)
        begin
            // Flush phase: any request pushes out the next pending pixel
            total     = w * h;
            first_out = total - w - 1;
            if (emitted < first_out || emitted >= total)
                emitted = first_out;
            if (emitted == first_out)
                res.color = upper_store[w - 1];
            else
            begin
                idx = emitted - (total - w);
                if (idx >= w)
                    idx = w - 1;
                res.color = middle_store[idx];
            end
            res.frame_end = (emitted + 1 == total);
            emitted++;
            if (res.frame_end)
                restart_frame_model();
            return 1'b1;
        end
        if (mode == MODE_PAD)
            return 1'b0;
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = row_pos;
        top = upper_store[c];
        mid = middle_store[c];
        upper_store[c]  = mid;
        middle_store[c] = color;
        for (int k = 0; k < WINDOW; k++)
        begin
            nbr_window[k * WINDOW]     = nbr_window[k * WINDOW + 1];
            nbr_window[k * WINDOW + 1] = nbr_window[k * WINDOW + 2];
        end
        nbr_window[WINDOW - 1]     = top;
        nbr_window[2 * WINDOW - 1] = mid;
        nbr_window[3 * WINDOW - 1] = color;
        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = r + 1;
        end
        if (r >= 2 || (r == 1 && c >= 1))
        begin
            if (r >= 2 && c >= 2)
                res.color = {window_median(2 * CH_W), window_median(CH_W),
                             window_median(0)};
            else
                res.color = nbr_window[WINDOW + 1];
            emitted = (emitted + 1) & 32'h7F_FFFF;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------------
    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic chan_t pick_channel();
        case (color_style)
            COLOR_EXTREME: return ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                  ^ chan_t'($urandom_range(0, 1));
            COLOR_NARROW:  return chan_t'($urandom_range(100, 103));
            default:       return chan_t'($urandom);
        endcase
    endfunction

    function automatic pixel_t pick_color();
        pixel_t c;
        c.red   = pick_channel();
        c.green = pick_channel();
        c.blue  = pick_channel();
        return c;
    endfunction

    task automatic send_request(input logic mode, input pixel_t color);
        int         gap;
        bit         dropped;
        out_pixel_t res;
        gap = tx_idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.mode  <= mode;
        pixel_ch.red   <= color.red;
        pixel_ch.green <= color.green;
        pixel_ch.blue  <= color.blue;
        @(posedge clk);
        while (pixel_ch.ready !== 1'b1)
            @(posedge clk);
        dropped = (mode == MODE_PAD) && (row_pos < eff_height());
        if (filter_request(mode, color, res))
            expected_pixels.push_back(res);
        if (dropped)
            pads_dropped++;
        else
            effective_items++;
    endtask

    // Drop valid and let every queued pixel come out plus the pipeline latency.
    task automatic wait_for_quiet();
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input int idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx << REG_LSB);
        pwdata  <= {(DATA_W - CFG_W)'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_WIDTH)
            cfg_width = value;
        else
            cfg_height = value;
        restart_frame_model();
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_register(input int idx);
        logic [CFG_W-1:0] want;
        want = (idx == REG_WIDTH) ? cfg_width : cfg_height;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(idx << REG_LSB);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[CFG_W-1:0] !== want)
            note_mismatch($sformatf("register %0d readback: expected %0d, got %0d",
                                    idx, want, prdata[CFG_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_for_quiet();
        write_register(REG_WIDTH, w);
        read_register(REG_WIDTH);
        write_register(REG_HEIGHT, h);
        read_register(REG_HEIGHT);
    endtask

    // Send one frame of pixels and its flush; at break_at wait for all
    // results, then either go on or leave the frame unfinished.
    task automatic run_frame(input int break_at, input bit abandon);
        int w;
        int h;
        w = int'(eff_width());
        h = int'(eff_height());
        case ($urandom_range(0, 3))
            2:       color_style = COLOR_EXTREME;
            3:       color_style = COLOR_NARROW;
            default: color_style = COLOR_FULL;
        endcase
        for (int n = 0; n < w * h; n++)
        begin
            if (pad_noise && $urandom_range(0, 7) == 0)
                send_request(MODE_PAD, pick_color());
            send_request(MODE_PIXEL, pick_color());
            if (n == break_at)
            begin
                wait_for_quiet();
                if (abandon)
                    return;
            end
        end
        for (int n = 0; n <= w; n++)
            send_request(($urandom_range(0, 2) == 0) ? MODE_PIXEL : MODE_PAD,
                         pick_color());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_register_access();
        read_register(REG_WIDTH);
        read_register(REG_HEIGHT);
        set_size(12'd17, 12'd9);
    endtask

    task automatic test_directed_frame();
        pixel_t img [TAPS];
        img = '{24'h000000, 24'hFFFFFF, 24'h00FF00,
                24'hFF00FF, 24'h808080, 24'h7F7F7F,
                24'h0000FF, 24'hFF0000, 24'h010203};
        set_size(12'd3, 12'd3);
        // Pad at the start of a frame is dropped
        send_request(MODE_PAD, 24'hFFFFFF);
        for (int i = 0; i < TAPS; i++)
        begin
            send_request(MODE_PIXEL, img[i]);
            if (i == 4)
                send_request(MODE_PAD, 24'hAA55AA);
        end
        // Flush: a real pixel here only pushes, its color is dropped
        send_request(MODE_PAD, 24'h000000);
        send_request(MODE_PIXEL, 24'h123456);
        send_request(MODE_PAD, 24'h55AA55);
        send_request(MODE_PAD, 24'hFFFFFF);
        send_request(MODE_PAD, 24'h000000);
        wait_for_quiet();
    endtask

    task automatic test_size_extremes();
        pad_noise = 1'b1;
        set_size(12'd0, 12'd2);
        run_frame(-1, 1'b0);
        pad_noise = 1'b0;
        // Width clamps to the line store depth; run the start of such a frame
        set_size(12'd4095, 12'd0);
        run_frame(40, 1'b1);
        // Tallest frame: run its first rows, then leave it
        set_size(12'd3, 12'd4095);
        run_frame(200, 1'b1);
    endtask

    task automatic test_output_stall();
        set_size(12'd6, 12'd5);
        tx_idle_en    = 1'b0;
        stall_request = LONG_STALL;
        run_frame(-1, 1'b0);
        wait_for_quiet();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_sender_pause();
        set_size(12'd7, 12'd5);
        run_frame(17, 1'b0);
        set_size(12'd9, 12'd4);
        run_frame(20, 1'b1);
        // Rewrite restarts the abandoned frame
        set_size(12'd9, 12'd4);
        run_frame(-1, 1'b0);
    endtask

    task automatic test_random_frames();
        int               target;
        int               brk;
        bit               abandon;
        bit               must_restart;
        logic [CFG_W-1:0] w_raw;
        logic [CFG_W-1:0] h_raw;
        target       = effective_items + RANDOM_ITEMS;
        must_restart = 1'b1;
        while (effective_items < target)
        begin
            if (must_restart || $urandom_range(0, 3) != 0)
            begin
                w_raw = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(15, 40))
                                                    : CFG_W'($urandom_range(0, 14));
                h_raw = CFG_W'($urandom_range(0, 10));
                set_size(w_raw, h_raw);
            end
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            pad_noise  = $urandom_range(0, 1);
            brk        = -1;
            abandon    = 1'b0;
            if ($urandom_range(0, 5) == 0)
            begin
                brk     = $urandom_range(0, eff_width() * eff_height() - 1);
                abandon = $urandom_range(0, 1);
            end
            run_frame(brk, abandon);
            must_restart = abandon;
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int gap;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (stall_request > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall_request) @(posedge clk);
                stall_request = 0;
            end
            gap = rx_idle_en ? $urandom_range(0, 4) : 0;
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (result_ch.valid !== 1'b1)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        out_pixel_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            results_checked++;
            if (expected_pixels.size() == 0)
                note_mismatch($sformatf("unexpected result r=%02h g=%02h b=%02h fe=%0b",
                                        result_ch.out_red, result_ch.out_green,
                                        result_ch.out_blue, result_ch.frame_end));
            else
            begin
                want = expected_pixels.pop_front();
                if (result_ch.out_red !== want.color.red
                    || result_ch.out_green !== want.color.green
                    || result_ch.out_blue !== want.color.blue
                    || result_ch.frame_end !== want.frame_end)
                    note_mismatch($sformatf(
                        {"result %0d: expected r=%02h g=%02h b=%02h fe=%0b,",
                         " got r=%02h g=%02h b=%02h fe=%0b"},
                        results_checked, want.color.red, want.color.green,
                        want.color.blue, want.frame_end, result_ch.out_red,
                        result_ch.out_green, result_ch.out_blue, result_ch.frame_end));
                else if (want.frame_end)
                    frames_done++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n === 1'b1)
        begin
            if ((pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1)
                || (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
                || psel === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no request accepted for %0d cycles", quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        pixel_ch.valid <= 1'b0;
        pixel_ch.mode  <= MODE_PIXEL;
        pixel_ch.red   <= '0;
        pixel_ch.green <= '0;
        pixel_ch.blue  <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        tx_idle_en      = 1'b1;
        rx_idle_en      = 1'b1;
        pad_noise       = 1'b0;
        color_style     = COLOR_FULL;
        stall_request   = 0;
        mismatch_count  = 0;
        effective_items = 0;
        pads_dropped    = 0;
        results_checked = 0;
        frames_done     = 0;
        quiet_cycles    = 0;
        reset_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_directed_frame();
        test_size_extremes();
        test_output_stall();
        test_sender_pause();
        test_random_frames();

        wait_for_quiet();
        repeat (8) @(posedge clk);
        if (expected_pixels.size() != 0)
            note_mismatch($sformatf("%0d expected pixels never arrived",
                                    expected_pixels.size()));

        $display("Run covered %0d pixel and flush requests plus %0d dropped pads",
                 effective_items, pads_dropped);
        $display("%0d results checked over %0d complete frames, clamped and tall sizes",
                 results_checked, frames_done);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
